[rtl/tim_pkg.sv]
// Shared constants and types for the tick interval monitor.
package tim_pkg;

  localparam int WINDOW     = 16;
  localparam int TIME_BITS  = 32;
  localparam int EVENT_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int IDX_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_BITS   = $clog2(WINDOW + 1);
  localparam int TOTAL_BITS = TIME_BITS + IDX_BITS;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [CNT_BITS-1:0]   count_t;
  typedef logic [IDX_BITS-1:0]   index_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUB   = 6'b000010,
    S_ADD   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

endpackage

[rtl/tim_if.sv]
// Valid/ready channel interfaces for event input and result output.
interface tim_in_if;
  logic                          valid;
  logic                          ready;
  logic [tim_pkg::EVENT_BITS-1:0] event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

interface tim_out_if;
  logic                          valid;
  logic                          ready;
  logic [tim_pkg::OUT_BITS-1:0]  interval;
  logic [tim_pkg::OUT_BITS-1:0]  longest_interval;
  logic [tim_pkg::OUT_BITS-1:0]  mean_interval;
  logic [tim_pkg::CNT_BITS-1:0]  intervals_held;

  modport source (output valid, output interval, output longest_interval,
                  output mean_interval, output intervals_held, input ready);
  modport sink   (input valid, input interval, input longest_interval,
                  input mean_interval, input intervals_held, output ready);
endinterface

[rtl/tim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tim_div.sv]
// Restoring serial divider: window total over held count, one bit per cycle.
module tim_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tim_pkg::total_t dividend,
  input  tim_pkg::count_t divisor,
  output logic            done,
  output tim_pkg::total_t quotient
);
  import tim_pkg::*;

  localparam int STEP_BITS = $clog2(TOTAL_BITS + 1);

  logic                 busy;
  logic [STEP_BITS-1:0] steps;
  total_t               work;
  count_t               dvs;
  count_t               rem;
  logic [CNT_BITS:0]    rem_sh;
  logic [CNT_BITS:0]    rem_diff;
  logic                 fits;

  assign rem_sh   = {rem, work[TOTAL_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_BITS'(TOTAL_BITS);
        work  <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        // quotient bits shift in at the bottom as dividend bits leave the top
        rem   <= fits ? rem_diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
        work  <= {work[TOTAL_BITS-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/tick_interval_monitor_unit.sv]
// Tick interval monitor: event gaps, longest gap and windowed mean.
//
// Usage: events arrive on the evt channel (valid/ready), each carrying a
// free-running tick timestamp. For every accepted event one result item is
// offered on the res channel: the gap to the previous event (zero for the
// first), the longest gap since reset, the truncated mean of the gaps held
// (the last WINDOW gaps once the window is full) and the number of gaps held.
// Timing: after acceptance an event passes the S_SUB, S_ADD and S_START
// steps, then waits in S_DIV for the bit-serial divide of the window total,
// and S_OUT then loads the result register.
// evt.ready is high only while the sequencer is idle, so one event is in
// work at a time and no new event is taken until its result is registered.
// The result sits in an output register: the next event is accepted while an
// earlier result still waits. If the receiver stalls, the sequencer holds in
// its final step until the output register frees, and evt.ready stays low.
// Reset (rst, synchronous, active high) clears the gap history, the longest
// gap and the counters; the gap ring needs no clearing since a slot is read
// only after it has been written.
module tick_interval_monitor_unit (
  input logic       clk,
  input logic       rst,
  tim_in_if.sink    evt,
  tim_out_if.source res
);
  import tim_pkg::*;

  state_t state;
  time_t  last_time;
  time_t  gap;
  time_t  longest_seen;
  total_t window_total;
  count_t held_count;
  index_t oldest_slot;
  logic   window_full;

  time_t  now;
  time_t  ring_rdata;
  logic   ring_we;
  index_t ring_waddr;
  logic   div_start;
  logic   div_done;
  total_t div_quot;
  time_t  mean;
  logic   first;

  assign now   = TIME_BITS'(evt.event_time);
  assign first = (held_count == '0);

  assign evt.ready  = (state == S_IDLE);
  assign ring_we    = (state == S_ADD);
  assign ring_waddr = window_full ? oldest_slot : held_count[IDX_BITS-1:0];
  assign div_start  = (state == S_START);

  tim_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(gap),
    .raddr(oldest_slot),
    .rdata(ring_rdata)
  );

  tim_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(window_total),
    .divisor (held_count),
    .done    (div_done),
    .quotient(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_time    <= '0;
      longest_seen <= '0;
      window_total <= '0;
      held_count   <= '0;
      oldest_slot  <= '0;
      window_full  <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (res.valid && res.ready && (state != S_OUT)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            last_time <= now;
            if (first) begin
              gap <= '0;
            end else begin
              gap <= now - last_time;
              if ((now - last_time) > longest_seen) begin
                longest_seen <= now - last_time;
              end
            end
            state <= S_SUB;
          end
        end
        S_SUB: begin
          // ring read of the oldest slot lands this cycle
          if (window_full) begin
            window_total <= window_total - TOTAL_BITS'(ring_rdata);
          end
          state <= S_ADD;
        end
        S_ADD: begin
          window_total <= window_total + TOTAL_BITS'(gap);
          if (window_full) begin
            oldest_slot <= (oldest_slot == IDX_BITS'(WINDOW - 1)) ?
                           '0 : oldest_slot + 1'b1;
          end else begin
            held_count <= held_count + 1'b1;
            if (held_count == CNT_BITS'(WINDOW - 1)) begin
              window_full <= 1'b1;
              oldest_slot <= '0;
            end
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean  <= TIME_BITS'(div_quot);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid            <= 1'b1;
            res.interval         <= OUT_BITS'(gap);
            res.longest_interval <= OUT_BITS'(longest_seen);
            res.mean_interval    <= OUT_BITS'(mean);
            res.intervals_held   <= held_count;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/tim_result_checker.sv]
// Result checker for the tick interval monitor: predicts each result item and compares.
`timescale 1ns / 1ps

module tim_result_checker
  import tim_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tim_in_if    evt,
  tim_out_if   res,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [OUT_BITS-1:0] interval;
    logic [OUT_BITS-1:0] longest_interval;
    logic [OUT_BITS-1:0] mean_interval;
    count_t              intervals_held;
  } gap_stats_t;

  // predictor state
  time_t  prev_time;
  time_t  gap_ring [WINDOW];
  index_t oldest;
  count_t held;
  logic   ring_full;
  total_t gap_total;
  time_t  longest_gap;

  gap_stats_t expected_stats [$];
  int         errors;

  function automatic gap_stats_t gap_stats_for(time_t now);
    gap_stats_t s;
    time_t      gap;
    total_t     avg;
    gap = '0;
    // first event after reset has no predecessor: gap 0, longest untouched
    if (held != 0) begin
      gap = now - prev_time;
      if (gap > longest_gap) longest_gap = gap;
    end
    if (!ring_full) begin
      gap_ring[held[IDX_BITS-1:0]] = gap;
      held = held + 1'b1;
      gap_total = gap_total + total_t'(gap);
      if (held >= WINDOW) begin
        ring_full = 1'b1;
        oldest = '0;
      end
    end else begin
      gap_total = gap_total - total_t'(gap_ring[oldest]) + total_t'(gap);
      gap_ring[oldest] = gap;
      oldest = (oldest == index_t'(WINDOW - 1)) ? '0 : oldest + 1'b1;
    end
    avg = gap_total / total_t'(held);
    prev_time = now;
    s.interval         = gap[OUT_BITS-1:0];
    s.longest_interval = longest_gap[OUT_BITS-1:0];
    s.mean_interval    = avg[OUT_BITS-1:0];
    s.intervals_held   = held;
    return s;
  endfunction

  always @(posedge clk) begin
    gap_stats_t want;
    if (rst) begin
      prev_time = '0;
      oldest = '0;
      held = '0;
      ring_full = 1'b0;
      gap_total = '0;
      longest_gap = '0;
      expected_stats.delete();
      errors = 0;
    end else begin
      if (evt.valid && evt.ready)
        expected_stats.push_back(gap_stats_for(time_t'(evt.event_time)));
      if (res.valid && res.ready) begin
        if (expected_stats.size() == 0) begin
          $error("result item with no event waiting: interval %0d", res.interval);
          errors++;
        end else begin
          want = expected_stats.pop_front();
          if (res.interval !== want.interval) begin
            $error("interval: expected %0d, got %0d", want.interval, res.interval);
            errors++;
          end
          if (res.longest_interval !== want.longest_interval) begin
            $error("longest_interval: expected %0d, got %0d",
                   want.longest_interval, res.longest_interval);
            errors++;
          end
          if (res.mean_interval !== want.mean_interval) begin
            $error("mean_interval: expected %0d, got %0d",
                   want.mean_interval, res.mean_interval);
            errors++;
          end
          if (res.intervals_held !== want.intervals_held) begin
            $error("intervals_held: expected %0d, got %0d",
                   want.intervals_held, res.intervals_held);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_stats.size();
  end

endmodule

[tb/tb_tick_interval_monitor_unit.sv]
// Testbench top for the tick interval monitor: clock, reset, event stimulus, verdict.
`timescale 1ns / 1ps

module tb_tick_interval_monitor_unit;
  import tim_pkg::*;

  localparam int RANDOM_EVENTS = 1626;
  localparam int CALM_EVENTS   = 150;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 80;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   events_sent;
  int   cycles;
  logic calm;
  logic hold_on;
  int   rx_idle_pct;

  tim_in_if  evt ();
  tim_out_if res ();

  tick_interval_monitor_unit DUT (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res)
  );

  tim_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    evt.valid = 1'b0;
    evt.event_time = '0;
    res.ready = 1'b0;
    calm = 1'b0;
    hold_on = 1'b0;
    events_sent = 0;
    rx_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tick_interval_monitor_unit verification failed");
      $finish;
    end
  end

  // offer one event item and wait for it to be taken
  task automatic send_event(input time_t t);
    @(negedge clk);
    evt.valid <= 1'b1;
    evt.event_time <= t;
    do @(posedge clk); while (!evt.ready);
    events_sent++;
  endtask

  task automatic sender_gap(input int idle_pct);
    int n;
    if (calm || hold_on || $urandom_range(0, 99) >= idle_pct) return;
    n = $urandom_range(1, 14);
    @(negedge clk);
    evt.valid <= 1'b0;
    evt.event_time <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off, none in the calm tail
  initial begin
    int n;
    bit held_off;
    held_off = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_off && events_sent >= HOLD_AT) begin
        held_off = 1;
        hold_on = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_on = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
        n = $urandom_range(1, 14);
        res.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin
    time_t edge_times [24];
    time_t now;
    int    tx_idle_pct;
    int    kind;

    // first event, repeat, wrap of the counter, largest gaps, then fill the ring
    edge_times = '{32'h1234_5678, 32'h1234_5678, 32'hFFFF_FFF0, 32'h0000_0010,
                   32'h0000_000F, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0002, 32'h8000_0400, 32'h8001_0000,
                   32'h8001_0001, 32'h0001_0001, 32'h0001_0003, 32'hF000_0000,
                   32'hF000_0007, 32'h0000_0006, 32'h0000_0100, 32'h0000_0101};

    tx_idle_pct = 30;
    rx_idle_pct = 30;
    @(negedge clk);
    while (rst) @(negedge clk);

    foreach (edge_times[i]) begin
      sender_gap(tx_idle_pct);
      send_event(edge_times[i]);
    end
    now = edge_times[23];

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i % 100 == 0) begin
        // vary the idle density so some stretches run back to back
        case ($urandom_range(0, 2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 25;
          default: tx_idle_pct = 70;
        endcase
        case ($urandom_range(0, 2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 25;
          default: rx_idle_pct = 70;
        endcase
      end
      if (i == RANDOM_EVENTS - CALM_EVENTS) calm = 1'b1;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: now = now + time_t'($urandom_range(0, 15));
        3, 4:    now = now + time_t'($urandom_range(0, 32'hFFFF));
        5, 6:    now = now + time_t'($urandom);
        7:       now = now + time_t'($urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF));
        default: now = $urandom;  // unrelated timestamp
      endcase
      sender_gap(tx_idle_pct);
      send_event(now);
    end

    @(negedge clk);
    evt.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tick_interval_monitor_unit verification clean");
    end else begin
      $display("tick_interval_monitor_unit verification failed");
    end
    $finish;
  end

endmodule
